@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the value noise top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define VN_ASSERT(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// same-cycle implication
`define VN_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VN_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VN_ASSERT(name, clk, rst, cond, msg)
`define VN_IMPLY(name, clk, rst, ante, cons, msg)
`define VN_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

@@ hw/rtl/vn3_pkg.sv @@
// ----------------------------------------------------------------------------
// vn3_pkg
// Constants, types and helpers of the 3-D value noise pipeline.
// ----------------------------------------------------------------------------
package vn3_pkg;

   localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_ONE    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_TWO    = 64'h94d049bb133111eb;
   localparam logic [17:0] THREE_Q16  = 18'd196608;

   localparam int DIV_STEPS  = 32;   // quotient bits of the cell divide
   localparam int FRAC_BITS  = 16;   // bits of the fraction divide
   localparam int PIPE_DEPTH = 64;   // stages from accept to last blend
   localparam int CY_DELAY   = 5;
   localparam int CZ_DELAY   = 10;
   localparam int S_DELAY    = 9;

   typedef enum logic [1:0] {
      REG_SEED   = 2'd0,
      REG_SALT   = 2'd1,
      REG_PERIOD = 2'd2
   } csr_reg_type;

   typedef logic signed [15:0] sample_type;

   function automatic logic signed [16:0] blend_diff(sample_type a, sample_type b);
      return $signed({b[15], b}) - $signed({a[15], a});
   endfunction

   // a + prod/65536, rounding toward zero
   function automatic sample_type blend_sum(sample_type base, logic signed [33:0] prod);
      logic signed [33:0] adj;
      logic signed [17:0] sum;
      adj = prod[33] ? (prod + 34'sd65535) : prod;
      sum = $signed({{2{base[15]}}, base}) + $signed(adj[33:16]);
      return sum[15:0];
   endfunction

endpackage

@@ hw/rtl/vn3_mix.sv @@
// ----------------------------------------------------------------------------
// vn3_mix
// Five-stage pipelined splitmix64 finalizer; 64-bit products are split into
// 32-bit partial products with a register between product and sum.
// ----------------------------------------------------------------------------
module vn3_mix import vn3_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] v_in,
   output logic [63:0] v_out
);

   logic [63:0] add_in;
   logic [63:0] x_in, x_ff;
   logic [63:0] p1_lo_in, p1_lo_ff;
   logic [31:0] p1_a_in, p1_a_ff, p1_b_in, p1_b_ff;
   logic [63:0] y_sum, y_in, y_ff;
   logic [63:0] p2_lo_in, p2_lo_ff;
   logic [31:0] p2_a_in, p2_a_ff, p2_b_in, p2_b_ff;
   logic [63:0] z_sum, out_in, out_ff;

   assign add_in   = v_in + GOLDEN_INC;
   assign x_in     = add_in ^ (add_in >> 30);

   assign p1_lo_in = 64'(x_ff[31:0]) * 64'(MUL_ONE[31:0]);
   assign p1_a_in  = x_ff[31:0] * MUL_ONE[63:32];
   assign p1_b_in  = x_ff[63:32] * MUL_ONE[31:0];

   assign y_sum    = p1_lo_ff + {p1_a_ff + p1_b_ff, 32'd0};
   assign y_in     = y_sum ^ (y_sum >> 27);

   assign p2_lo_in = 64'(y_ff[31:0]) * 64'(MUL_TWO[31:0]);
   assign p2_a_in  = y_ff[31:0] * MUL_TWO[63:32];
   assign p2_b_in  = y_ff[63:32] * MUL_TWO[31:0];

   assign z_sum    = p2_lo_ff + {p2_a_ff + p2_b_ff, 32'd0};
   assign out_in   = z_sum ^ (z_sum >> 31);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= x_in;
         p1_lo_ff <= p1_lo_in;
         p1_a_ff  <= p1_a_in;
         p1_b_ff  <= p1_b_in;
         y_ff     <= y_in;
         p2_lo_ff <= p2_lo_in;
         p2_a_ff  <= p2_a_in;
         p2_b_ff  <= p2_b_in;
         out_ff   <= out_in;
      end
   end

   assign v_out = out_ff;

endmodule

@@ hw/rtl/vn3_axis.sv @@
// ----------------------------------------------------------------------------
// vn3_axis
// Per-axis lattice split: bit-per-stage floor divide by the cell period,
// bit-per-stage fraction divide, then the two-stage smoothstep weight.
// Cells come out of lo_ff and hi_ff after the floor fix in cell_ff; the weight comes out of prod_ff.
// ----------------------------------------------------------------------------
module vn3_axis import vn3_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] coord,
   input  logic [16:0]        period,
   output logic [31:0]        cell_lo,
   output logic [31:0]        cell_hi,
   output logic [15:0]        weight
);

   logic        neg;
   logic [31:0] mag;
   logic [16:0] rem_ff [0:DIV_STEPS-1];
   logic [31:0] quo_ff [0:DIV_STEPS-1];
   logic        neg_ff [0:DIV_STEPS-1];

   assign neg = coord[31];
   assign mag = neg ? (~coord + 32'd1) : coord;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [16:0] rem_prev;
      logic [31:0] quo_prev;
      logic        neg_prev;
      logic [17:0] cat;
      logic        ge;
      logic [16:0] rem_in;
      logic [31:0] quo_in;
      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = mag;
         assign neg_prev = neg;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign neg_prev = neg_ff[k-1];
      end
      assign cat    = {rem_prev, quo_prev[31]};
      assign ge     = cat >= {1'b0, period};
      assign rem_in = ge ? 17'(cat - {1'b0, period}) : cat[16:0];
      assign quo_in = {quo_prev[30:0], ge};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            neg_ff[k] <= neg_prev;
         end
      end
   end

   // turn the truncated quotient into a floor quotient
   logic [16:0] rem_last;
   logic [31:0] quo_last;
   logic        wrap;
   logic [31:0] cell_in, cell_ff;
   logic [16:0] frac_in, frac_ff;
   logic [31:0] lo_ff, hi_ff;
   logic [16:0] fr_ff;

   assign rem_last = rem_ff[DIV_STEPS-1];
   assign quo_last = quo_ff[DIV_STEPS-1];
   assign wrap     = neg_ff[DIV_STEPS-1] && (rem_last != 17'd0);
   assign cell_in  = wrap ? ~quo_last :
                     (neg_ff[DIV_STEPS-1] ? (~quo_last + 32'd1) : quo_last);
   assign frac_in  = wrap ? (period - rem_last) : rem_last;

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
         frac_ff <= frac_in;
         lo_ff   <= cell_ff;
         hi_ff   <= cell_ff + 32'd1;
         fr_ff   <= frac_ff;
      end
   end

   assign cell_lo = lo_ff;
   assign cell_hi = hi_ff;

   logic [16:0] trem_ff [0:FRAC_BITS-1];
   logic [15:0] tq_ff   [0:FRAC_BITS-1];

   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_frac
      logic [16:0] trem_prev;
      logic [15:0] tq_prev;
      logic [17:0] cat;
      logic        ge;
      logic [16:0] trem_in;
      logic [15:0] tq_in;
      if (j == 0) begin : g_first
         assign trem_prev = fr_ff;
         assign tq_prev   = '0;
      end else begin : g_next
         assign trem_prev = trem_ff[j-1];
         assign tq_prev   = tq_ff[j-1];
      end
      assign cat     = {trem_prev, 1'b0};
      assign ge      = cat >= {1'b0, period};
      assign trem_in = ge ? 17'(cat - {1'b0, period}) : cat[16:0];
      assign tq_in   = {tq_prev[14:0], ge};
      always_ff @(posedge clock) begin
         if (en) begin
            trem_ff[j] <= trem_in;
            tq_ff[j]   <= tq_in;
         end
      end
   end

   logic [15:0] t;
   logic [31:0] sq_in, sq_ff;
   logic [17:0] lin_in, lin_ff;
   logic [33:0] prod_in, prod_ff;

   assign t       = tq_ff[FRAC_BITS-1];
   assign sq_in   = 32'(t) * 32'(t);
   assign lin_in  = THREE_Q16 - {1'b0, t, 1'b0};
   assign prod_in = 34'(sq_ff[31:16]) * 34'(lin_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         lin_ff  <= lin_in;
         prod_ff <= prod_in;
      end
   end

   // smoothstep never reaches 1.0, so the weight fits 16 bits
   assign weight = prod_ff[31:16];

endmodule

@@ hw/rtl/value_noise_3d_top.sv @@
// ----------------------------------------------------------------------------
// value_noise_3d_top
// Trilinear value noise with smoothstep weights at a signed 3-D point.
//
//   channel  direction  handshake                beat
//   req      in         req_valid / req_stall    x, y, z coordinates
//   rsp      out        rsp_valid / rsp_stall    noise_value
//   csr      in         APB, pready tied high    seed, salt, cell period
//
// One point enters per cycle while req_stall is low; each result passes
// through the 32 cell-divide stages, the chained hash units and three
// blend levels. Reset clears the valid bits and the csr registers to their
// defaults. A held result parks in a one-beat skid stage; only when that is
// full does req_stall rise and the whole pipeline hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module value_noise_3d_top import vn3_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_z_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   // configuration
   logic [31:0] seed_ff;
   logic [63:0] salt_ff;
   logic [16:0] period_ff;
   logic [16:0] period;
   csr_reg_type csr_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_reg_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         salt_ff   <= '0;
         period_ff <= 17'd32;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SEED:   seed_ff   <= csr_pwdata[31:0];
            REG_SALT:   salt_ff   <= csr_pwdata;
            REG_PERIOD: period_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SEED:   csr_prdata = {32'd0, seed_ff};
         REG_SALT:   csr_prdata = salt_ff;
         REG_PERIOD: csr_prdata = {47'd0, period_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // a zero period acts as one
   assign period = (period_ff == 17'd0) ? 17'd1 : period_ff;

   // pipeline control
   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  skid_vld_ff;
   logic signed [15:0]    skid_data_ff;
   logic                  rsp_valid_ff;
   logic signed [15:0]    rsp_data_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   logic signed [31:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_x_coord;
         y_ff <= req_y_coord;
         z_ff <= req_z_coord;
      end
   end

   logic [31:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
   logic [15:0] sx_raw, sy_raw, sz_raw;

   vn3_axis u_axis_x (
      .clock   (clock),
      .en      (en),
      .coord   (x_ff),
      .period  (period),
      .cell_lo (x_lo),
      .cell_hi (x_hi),
      .weight  (sx_raw)
   );

   vn3_axis u_axis_y (
      .clock   (clock),
      .en      (en),
      .coord   (y_ff),
      .period  (period),
      .cell_lo (y_lo),
      .cell_hi (y_hi),
      .weight  (sy_raw)
   );

   vn3_axis u_axis_z (
      .clock   (clock),
      .en      (en),
      .coord   (z_ff),
      .period  (period),
      .cell_lo (z_lo),
      .cell_hi (z_hi),
      .weight  (sz_raw)
   );

   // line up y and z cells and the weights with the hash and blend stages
   logic [31:0] cy_dly_ff [0:CY_DELAY-1][0:1];
   logic [31:0] cz_dly_ff [0:CZ_DELAY-1][0:1];
   logic [15:0] s_dly_ff  [0:2][0:S_DELAY-1];

   always_ff @(posedge clock) begin
      if (en) begin
         cy_dly_ff[0][0] <= y_lo;
         cy_dly_ff[0][1] <= y_hi;
         for (int i = 1; i < CY_DELAY; i++) begin
            cy_dly_ff[i] <= cy_dly_ff[i-1];
         end
         cz_dly_ff[0][0] <= z_lo;
         cz_dly_ff[0][1] <= z_hi;
         for (int i = 1; i < CZ_DELAY; i++) begin
            cz_dly_ff[i] <= cz_dly_ff[i-1];
         end
         s_dly_ff[0][0] <= sx_raw;
         s_dly_ff[1][0] <= sy_raw;
         s_dly_ff[2][0] <= sz_raw;
         for (int i = 1; i < S_DELAY; i++) begin
            s_dly_ff[0][i] <= s_dly_ff[0][i-1];
            s_dly_ff[1][i] <= s_dly_ff[1][i-1];
            s_dly_ff[2][i] <= s_dly_ff[2][i-1];
         end
      end
   end

   // corner hash chain
   logic [63:0] h0;
   logic [63:0] h1 [0:1];
   logic [63:0] h2 [0:3];
   logic [63:0] h3 [0:7];
   logic [63:0] h4 [0:7];
   logic [31:0] cx [0:1];

   assign cx[0] = x_lo;
   assign cx[1] = x_hi;

   // seed term runs free; it settles long before an item reaches the chain
   vn3_mix u_mix_seed (
      .clock (clock),
      .en    (1'b1),
      .v_in  ({32'd0, seed_ff}),
      .v_out (h0)
   );

   for (genvar i = 0; i < 2; i++) begin : g_hx
      vn3_mix u_mix (
         .clock (clock),
         .en    (en),
         .v_in  (h0 ^ {32'd0, cx[i]}),
         .v_out (h1[i])
      );
   end

   for (genvar c = 0; c < 4; c++) begin : g_hy
      vn3_mix u_mix (
         .clock (clock),
         .en    (en),
         .v_in  (h1[c % 2] ^ {32'd0, cy_dly_ff[CY_DELAY-1][c / 2]}),
         .v_out (h2[c])
      );
   end

   for (genvar c = 0; c < 8; c++) begin : g_hz
      vn3_mix u_mix_z (
         .clock (clock),
         .en    (en),
         .v_in  (h2[c % 4] ^ {32'd0, cz_dly_ff[CZ_DELAY-1][c / 4]}),
         .v_out (h3[c])
      );
      vn3_mix u_mix_salt (
         .clock (clock),
         .en    (en),
         .v_in  (h3[c] ^ salt_ff),
         .v_out (h4[c])
      );
   end

   sample_type cv [0:7];

   for (genvar c = 0; c < 8; c++) begin : g_cv
      assign cv[c] = {~h4[c][15], h4[c][14:0]};
   end

   // blend along x
   logic signed [16:0] dx_ff  [0:3];
   sample_type         bx_ff  [0:3];
   sample_type         bx2_ff [0:3];
   logic signed [33:0] px_ff  [0:3];
   sample_type         xb_ff  [0:3];

   for (genvar l = 0; l < 4; l++) begin : g_bx
      logic signed [33:0] px_in;
      assign px_in = 34'(dx_ff[l]) * 34'($signed({1'b0, s_dly_ff[0][2]}));
      always_ff @(posedge clock) begin
         if (en) begin
            dx_ff[l]  <= blend_diff(cv[2*l], cv[2*l+1]);
            bx_ff[l]  <= cv[2*l];
            px_ff[l]  <= px_in;
            bx2_ff[l] <= bx_ff[l];
            xb_ff[l]  <= blend_sum(bx2_ff[l], px_ff[l]);
         end
      end
   end

   // blend along y
   logic signed [16:0] dy_ff  [0:1];
   sample_type         by_ff  [0:1];
   sample_type         by2_ff [0:1];
   logic signed [33:0] py_ff  [0:1];
   sample_type         yb_ff  [0:1];

   for (genvar l = 0; l < 2; l++) begin : g_by
      logic signed [33:0] py_in;
      assign py_in = 34'(dy_ff[l]) * 34'($signed({1'b0, s_dly_ff[1][5]}));
      always_ff @(posedge clock) begin
         if (en) begin
            dy_ff[l]  <= blend_diff(xb_ff[2*l], xb_ff[2*l+1]);
            by_ff[l]  <= xb_ff[2*l];
            py_ff[l]  <= py_in;
            by2_ff[l] <= by_ff[l];
            yb_ff[l]  <= blend_sum(by2_ff[l], py_ff[l]);
         end
      end
   end

   // blend along z
   logic signed [16:0] dz_ff;
   sample_type         bz_ff, bz2_ff, zb_ff;
   logic signed [33:0] pz_ff, pz_in;

   assign pz_in = 34'(dz_ff) * 34'($signed({1'b0, s_dly_ff[2][8]}));

   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff  <= blend_diff(yb_ff[0], yb_ff[1]);
         bz_ff  <= yb_ff[0];
         pz_ff  <= pz_in;
         bz2_ff <= bz_ff;
         zb_ff  <= blend_sum(bz2_ff, pz_ff);
      end
   end

   // output register with one-beat skid
   logic out_free;
   logic arrive;
   logic out_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign arrive   = en && vld_ff[PIPE_DEPTH-1];
   assign out_last = rsp_valid_ff && !rsp_stall && !skid_vld_ff && !vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= skid_data_ff;
            skid_vld_ff  <= 1'b0;
         end else begin
            rsp_valid_ff <= arrive;
            if (arrive) begin
               rsp_data_ff <= zb_ff;
            end
         end
      end else if (arrive) begin
         // hold the new beat behind the stalled one
         skid_vld_ff  <= 1'b1;
         skid_data_ff <= zb_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_data_ff;

   `VN_IMPLY(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_valid_ff, "skid without output")
   `VN_NEXT(a_pipe_hold, clock, reset, skid_vld_ff, vld_ff == $past(vld_ff), "pipeline moved")
   `VN_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0], "beat lost")
   `VN_NEXT(a_drain, clock, reset, out_last, !rsp_valid_ff, "result repeated after drain")

endmodule
